// ===== design/lsfw_pkg.sv =====
package lsfw_pkg;

  // fixed frame constants
  localparam int ID_BITS   = 3;
  localparam int CMD_W     = 8;
  localparam int CMD_BITS  = CMD_W + 1;
  localparam int DATA_BITS = 8;
  localparam int ADDR_W    = 7;

  localparam logic [ID_BITS-1:0] ID_CMD  = 3'b100;
  localparam logic [ID_BITS-1:0] ID_DATA = 3'b101;

  // item operation codes
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // sequencer steps
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD_ID,
    ST_CMD,
    ST_DAT_ID,
    ST_ADDR,
    ST_DATA
  } step_t;

  // shift register load sources
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_CMD_ID,
    SRC_CMD,
    SRC_DAT_ID,
    SRC_ADDR,
    SRC_DATA
  } src_t;

  // how the last bit of a segment is marked
  typedef enum logic [1:0] {
    LAST_NONE,
    LAST_ALWAYS,
    LAST_EOB
  } last_t;

  // burst state update at end of segment
  typedef enum logic [1:0] {
    BURST_KEEP,
    BURST_CLEAR,
    BURST_EOB
  } burst_t;

  typedef enum logic {
    JMP_SEQ,
    JMP_DISPATCH
  } jump_t;

  typedef struct packed {
    logic   emit;
    src_t   src;
    last_t  last;
    burst_t burst;
    jump_t  jump;
    step_t  next_step;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    ucode_t word;
    logic   load;
    logic   from_port;
    src_t   load_src;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic adv;
    logic seg_done;
    logic burst_open;
  } stat_t;

  // microprogram rom
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{emit: 1'b0, src: SRC_NONE, last: LAST_NONE, burst: BURST_KEEP,
          jump: JMP_DISPATCH, next_step: ST_IDLE};
    case (step)
      ST_IDLE: begin
        w = '{emit: 1'b0, src: SRC_NONE, last: LAST_NONE, burst: BURST_KEEP,
              jump: JMP_DISPATCH, next_step: ST_IDLE};
      end
      ST_CMD_ID: begin
        w = '{emit: 1'b1, src: SRC_CMD_ID, last: LAST_NONE, burst: BURST_KEEP,
              jump: JMP_SEQ, next_step: ST_CMD};
      end
      ST_CMD: begin
        w = '{emit: 1'b1, src: SRC_CMD, last: LAST_ALWAYS, burst: BURST_CLEAR,
              jump: JMP_SEQ, next_step: ST_IDLE};
      end
      ST_DAT_ID: begin
        w = '{emit: 1'b1, src: SRC_DAT_ID, last: LAST_NONE, burst: BURST_KEEP,
              jump: JMP_SEQ, next_step: ST_ADDR};
      end
      ST_ADDR: begin
        w = '{emit: 1'b1, src: SRC_ADDR, last: LAST_NONE, burst: BURST_KEEP,
              jump: JMP_SEQ, next_step: ST_DATA};
      end
      ST_DATA: begin
        w = '{emit: 1'b1, src: SRC_DATA, last: LAST_EOB, burst: BURST_EOB,
              jump: JMP_SEQ, next_step: ST_IDLE};
      end
      default: begin
        w = '{emit: 1'b0, src: SRC_NONE, last: LAST_NONE, burst: BURST_KEEP,
              jump: JMP_DISPATCH, next_step: ST_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/lsfw_sequencer.sv =====
module lsfw_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic            op,
  input  lsfw_pkg::stat_t stat,
  output lsfw_pkg::ctrl_t ctrl,
  output logic            item_stall
);

  lsfw_pkg::step_t  step;
  lsfw_pkg::step_t  step_next;
  lsfw_pkg::ucode_t word;
  lsfw_pkg::ucode_t next_word;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lsfw_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // control word fetch, dispatch and sequencing
  always_comb begin
    word           = lsfw_pkg::ucode_rom(step);
    step_next      = step;
    ctrl.load      = 1'b0;
    ctrl.from_port = 1'b0;
    if (word.jump == lsfw_pkg::JMP_DISPATCH) begin
      if (item_valid) begin
        ctrl.load      = 1'b1;
        ctrl.from_port = 1'b1;
        if (op == lsfw_pkg::OP_CMD) begin
          step_next = lsfw_pkg::ST_CMD_ID;
        end else if (!stat.burst_open) begin
          step_next = lsfw_pkg::ST_DAT_ID;
        end else begin
          step_next = lsfw_pkg::ST_DATA;
        end
      end
    end else if (stat.seg_done) begin
      step_next = word.next_step;
      ctrl.load = 1'b1;
    end
    // the step that follows picks the load source; idle loads nothing
    next_word     = lsfw_pkg::ucode_rom(step_next);
    ctrl.load     = ctrl.load && next_word.emit;
    ctrl.word     = word;
    ctrl.load_src = next_word.src;
    item_stall    = (word.jump != lsfw_pkg::JMP_DISPATCH);
  end

endmodule

// ===== design/lsfw_datapath.sv =====
module lsfw_datapath #(
  parameter int ADDRESS_BITS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lsfw_pkg::ctrl_t               ctrl,
  input  logic [lsfw_pkg::CMD_W-1:0]    command_code,
  input  logic [lsfw_pkg::ADDR_W-1:0]   address,
  input  logic [lsfw_pkg::DATA_BITS-1:0] data_byte,
  input  logic                          end_of_burst,
  input  logic                          slot_stall,
  output logic                          slot_valid,
  output logic                          data_bit,
  output logic                          frame_last,
  output lsfw_pkg::stat_t               stat
);

  localparam int SHW = (ADDRESS_BITS > lsfw_pkg::CMD_BITS) ? ADDRESS_BITS
                                                           : lsfw_pkg::CMD_BITS;
  localparam int CW  = $clog2(SHW + 1);

  logic [lsfw_pkg::CMD_W-1:0]     cmd_r;
  logic [lsfw_pkg::ADDR_W-1:0]    addr_r;
  logic [lsfw_pkg::DATA_BITS-1:0] data_r;
  logic                           eob_r;

  logic [lsfw_pkg::CMD_W-1:0]     cmd_s;
  logic [lsfw_pkg::ADDR_W-1:0]    addr_s;
  logic [lsfw_pkg::DATA_BITS-1:0] data_s;
  logic [lsfw_pkg::DATA_BITS-1:0] data_rev;
  logic [ADDRESS_BITS-1:0]        addr_w;

  logic [SHW-1:0] shreg;
  logic [CW-1:0]  cnt;
  logic [SHW-1:0] load_val;
  logic [CW-1:0]  load_len;
  logic           burst_open;
  logic           adv;
  logic           seg_end;
  logic           mark_last;

  // operand select: ports on dispatch, held copies afterwards
  assign cmd_s  = ctrl.from_port ? command_code : cmd_r;
  assign addr_s = ctrl.from_port ? address      : addr_r;
  assign data_s = ctrl.from_port ? data_byte    : data_r;
  assign addr_w = ADDRESS_BITS'(addr_s);

  // data goes out lsb first, so load it reversed
  always_comb begin
    for (int i = 0; i < lsfw_pkg::DATA_BITS; i++) begin
      data_rev[i] = data_s[lsfw_pkg::DATA_BITS-1-i];
    end
  end

  // segment value, left aligned, and its bit count
  always_comb begin
    case (ctrl.load_src)
      lsfw_pkg::SRC_CMD_ID: begin
        load_val = SHW'(lsfw_pkg::ID_CMD) << (SHW - lsfw_pkg::ID_BITS);
        load_len = CW'(lsfw_pkg::ID_BITS);
      end
      lsfw_pkg::SRC_CMD: begin
        load_val = SHW'({cmd_s, 1'b0}) << (SHW - lsfw_pkg::CMD_BITS);
        load_len = CW'(lsfw_pkg::CMD_BITS);
      end
      lsfw_pkg::SRC_DAT_ID: begin
        load_val = SHW'(lsfw_pkg::ID_DATA) << (SHW - lsfw_pkg::ID_BITS);
        load_len = CW'(lsfw_pkg::ID_BITS);
      end
      lsfw_pkg::SRC_ADDR: begin
        load_val = SHW'(addr_w) << (SHW - ADDRESS_BITS);
        load_len = CW'(ADDRESS_BITS);
      end
      lsfw_pkg::SRC_DATA: begin
        load_val = SHW'(data_rev) << (SHW - lsfw_pkg::DATA_BITS);
        load_len = CW'(lsfw_pkg::DATA_BITS);
      end
      default: begin
        load_val = '0;
        load_len = '0;
      end
    endcase
  end

  // one bit slot per cycle while the output register can take it
  assign adv     = ctrl.word.emit && (!slot_valid || !slot_stall);
  assign seg_end = (cnt == CW'(1));
  assign mark_last = seg_end &&
                     ((ctrl.word.last == lsfw_pkg::LAST_ALWAYS) ||
                      ((ctrl.word.last == lsfw_pkg::LAST_EOB) && eob_r));

  // item capture
  always_ff @(posedge clk) begin
    if (ctrl.load && ctrl.from_port) begin
      cmd_r  <= command_code;
      addr_r <= address;
      data_r <= data_byte;
      eob_r  <= end_of_burst;
    end
  end

  // shift register and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= load_len;
    end else if (adv) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shreg <= load_val;
    end else if (adv) begin
      shreg <= shreg << 1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (adv) begin
      slot_valid <= 1'b1;
    end else if (!slot_stall) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_bit   <= shreg[SHW-1];
      frame_last <= mark_last;
    end
  end

  // burst state
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_open <= 1'b0;
    end else if (adv && seg_end) begin
      case (ctrl.word.burst)
        lsfw_pkg::BURST_CLEAR: burst_open <= 1'b0;
        lsfw_pkg::BURST_EOB:   burst_open <= !eob_r;
        default:               burst_open <= burst_open;
      endcase
    end
  end

  assign stat.adv        = adv;
  assign stat.seg_done   = adv && seg_end;
  assign stat.burst_open = burst_open;

endmodule

// ===== design/led_driver_serial_frame_writer.sv =====
// channel  valid       stall       beat fields
// item     item_valid  item_stall  op, command_code, address, data_byte, end_of_burst
// slot     slot_valid  slot_stall  select_active, data_bit, frame_last
//
// one bit slot per clock unless stalled, from a shift register run by the microcode
// command item: id and command bits, first data item of a burst: id, address, byte;
//   later data item: data byte only, each after a dispatch in the idle step
// rst is synchronous and clears the step counter, bit counter, burst flag and slot_valid
// slot_stall freezes the emitting steps; item_stall is high outside the idle step
module led_driver_serial_frame_writer #(
  parameter int ADDRESS_BITS = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           op,
  input  logic [lsfw_pkg::CMD_W-1:0]     command_code,
  input  logic [lsfw_pkg::ADDR_W-1:0]    address,
  input  logic [lsfw_pkg::DATA_BITS-1:0] data_byte,
  input  logic                           end_of_burst,
  output logic                           slot_valid,
  input  logic                           slot_stall,
  output logic                           select_active,
  output logic                           data_bit,
  output logic                           frame_last
);

  lsfw_pkg::ctrl_t ctrl;
  lsfw_pkg::stat_t stat;

  // microprogram sequencer
  lsfw_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .op         (op),
    .stat       (stat),
    .ctrl       (ctrl),
    .item_stall (item_stall)
  );

  // shift datapath and output register
  lsfw_datapath #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .command_code (command_code),
    .address      (address),
    .data_byte    (data_byte),
    .end_of_burst (end_of_burst),
    .slot_stall   (slot_stall),
    .slot_valid   (slot_valid),
    .data_bit     (data_bit),
    .frame_last   (frame_last),
    .stat         (stat)
  );

  // every slot lies inside a frame
  assign select_active = 1'b1;

`ifndef SYNTHESIS
  // an accepted item always starts an emitting step
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("sequencer did not leave idle after accepting an item");

  // no bit slot is produced while the sequencer waits for an item
  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> !stat.adv)
    else $error("bit slot emitted from idle step");

  // a marked last bit means no burst stays open
  a_last_closes_burst: assert property (@(posedge clk) disable iff (rst)
    slot_valid && frame_last |-> !stat.burst_open)
    else $error("burst still open after marked last bit");
`endif

endmodule

// ===== verif/led_driver_serial_frame_writer_tb.sv =====
module led_driver_serial_frame_writer_tb;

  localparam int ADDR_BITS    = 7;
  localparam int RANDOM_ITEMS = 200;
  localparam int CALM_ITEMS   = 40;
  localparam int TIMEOUT      = 4_000_000;

  // one serial bit slot as seen on the slot channel
  typedef struct packed {
    logic sel;
    logic dbit;
    logic last;
  } slot_t;

  // predicts the bit slots of each item and checks them in order
  class slot_board;
    slot_t expected_slots[$];
    bit    burst_open;
    int    mismatches;
    int    slots_checked;
    int    cmd_items;
    int    data_items;
    int    cut_bursts;

    function void add_slot(logic b, logic last);
      slot_t s;
      s.sel  = 1'b1;
      s.dbit = b;
      s.last = last;
      expected_slots.push_back(s);
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    function void take_item(logic o, logic [lsfw_pkg::CMD_W-1:0] cmd,
                            logic [lsfw_pkg::ADDR_W-1:0] addr,
                            logic [lsfw_pkg::DATA_BITS-1:0] data, logic eob);
      logic [lsfw_pkg::CMD_BITS-1:0] cmd_word;
      logic [31:0]                   addr_word;
      int                            i;
      if (o == lsfw_pkg::OP_CMD) begin
        // command frame: id, command msb first, then a trailing zero
        cmd_items++;
        if (burst_open) cut_bursts++;
        burst_open = 1'b0;
        cmd_word = {cmd, 1'b0};
        for (i = lsfw_pkg::ID_BITS - 1; i >= 0; i--) add_slot(lsfw_pkg::ID_CMD[i], 1'b0);
        for (i = lsfw_pkg::CMD_BITS - 1; i >= 0; i--) add_slot(cmd_word[i], i == 0);
      end else begin
        // first byte of a burst carries id and start address
        data_items++;
        if (!burst_open) begin
          addr_word = 32'(addr);
          for (i = lsfw_pkg::ID_BITS - 1; i >= 0; i--)
            add_slot(lsfw_pkg::ID_DATA[i], 1'b0);
          for (i = ADDR_BITS - 1; i >= 0; i--) add_slot(addr_word[i], 1'b0);
        end
        // byte goes out lsb first
        for (i = 0; i < lsfw_pkg::DATA_BITS; i++)
          add_slot(data[i], eob && (i == lsfw_pkg::DATA_BITS - 1));
        burst_open = !eob;
      end
    endfunction

    function void check_slot(logic sel, logic dbit, logic last);
      slot_t want;
      slots_checked++;
      if (expected_slots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: slot beat with nothing expected: sel=%b bit=%b last=%b",
                   $time, sel, dbit, last);
      end else begin
        want = expected_slots.pop_front();
        if (sel !== want.sel || dbit !== want.dbit || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: slot %0d: expected sel=%b bit=%b last=%b, got sel=%b bit=%b last=%b",
                     $time, slots_checked, want.sel, want.dbit, want.last, sel, dbit, last);
        end
      end
    endfunction
  endclass

  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           item_valid   = 1'b0;
  logic                           item_stall;
  logic                           op           = 1'b0;
  logic [lsfw_pkg::CMD_W-1:0]     command_code = '0;
  logic [lsfw_pkg::ADDR_W-1:0]    address      = '0;
  logic [lsfw_pkg::DATA_BITS-1:0] data_byte    = '0;
  logic                           end_of_burst = 1'b0;
  logic                           slot_valid;
  logic                           slot_stall   = 1'b0;
  logic                           select_active;
  logic                           data_bit;
  logic                           frame_last;

  bit        idle_on    = 1'b1;
  int        stall_left = 0;
  int        items_sent = 0;
  slot_board board      = new;

  led_driver_serial_frame_writer #(
    .ADDRESS_BITS(ADDR_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .command_code (command_code),
    .address      (address),
    .data_byte    (data_byte),
    .end_of_burst (end_of_burst),
    .slot_valid   (slot_valid),
    .slot_stall   (slot_stall),
    .select_active(select_active),
    .data_bit     (data_bit),
    .frame_last   (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accepted beats on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall)
        board.take_item(op, command_code, address, data_byte, end_of_burst);
      if (slot_valid && !slot_stall)
        board.check_slot(select_active, data_bit, frame_last);
    end
  end

  // receiver stalls at random in bursts while idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      slot_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      slot_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      slot_stall <= 1'b0;
    end
  end

  // one item beat, with an optional gap in front of it
  task automatic send_item(logic o, logic [lsfw_pkg::CMD_W-1:0] cmd,
                           logic [lsfw_pkg::ADDR_W-1:0] addr,
                           logic [lsfw_pkg::DATA_BITS-1:0] data, logic eob);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_valid   <= 1'b1;
    op           <= o;
    command_code <= cmd;
    address      <= addr;
    data_byte    <= data;
    end_of_burst <= eob;
    do @(posedge clk); while (!(item_valid && !item_stall));
    items_sent++;
  endtask

  // holds the sender back until every predicted slot is out
  task automatic drain_slots();
    item_valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int  directed;
    int  len;
    int  k;
    bit  cut;
    bit  paused;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: command extremes, burst shapes, command cutting a burst
    send_item(lsfw_pkg::OP_CMD, 8'h00, 7'($urandom_range(0, 127)),
              8'($urandom_range(0, 255)), 1'b1);
    send_item(lsfw_pkg::OP_CMD, 8'hff, 7'($urandom_range(0, 127)),
              8'($urandom_range(0, 255)), 1'b0);
    send_item(lsfw_pkg::OP_CMD, 8'h5a, 7'h7f, 8'hff, 1'b1);
    send_item(lsfw_pkg::OP_DATA, 8'($urandom_range(0, 255)), 7'h00, 8'h00, 1'b1);
    send_item(lsfw_pkg::OP_DATA, 8'($urandom_range(0, 255)), 7'h7f, 8'hff, 1'b0);
    send_item(lsfw_pkg::OP_DATA, 8'hff, 7'h2a, 8'h5a, 1'b0);
    send_item(lsfw_pkg::OP_DATA, 8'h00, 7'h55, 8'h81, 1'b1);
    send_item(lsfw_pkg::OP_DATA, 8'($urandom_range(0, 255)), 7'h55, 8'ha5, 1'b0);
    send_item(lsfw_pkg::OP_CMD, 8'h80, 7'h00, 8'h00, 1'b0);
    send_item(lsfw_pkg::OP_DATA, 8'($urandom_range(0, 255)), 7'h7f, 8'h01, 1'b1);
    send_item(lsfw_pkg::OP_DATA, 8'($urandom_range(0, 255)), 7'h01, 8'h80, 1'b0);
    send_item(lsfw_pkg::OP_DATA, 8'($urandom_range(0, 255)), 7'h00, 8'h7e, 1'b0);
    send_item(lsfw_pkg::OP_CMD, 8'h01, 7'h7f, 8'hff, 1'b1);
    send_item(lsfw_pkg::OP_CMD, 8'ha0, 7'($urandom_range(0, 127)),
              8'($urandom_range(0, 255)), 1'b0);
    send_item(lsfw_pkg::OP_CMD, 8'h03, 7'($urandom_range(0, 127)),
              8'($urandom_range(0, 255)), 1'b1);
    send_item(lsfw_pkg::OP_DATA, 8'h5a, 7'h40, 8'hc3, 1'b1);
    send_item(lsfw_pkg::OP_DATA, 8'ha5, 7'h3f, 8'h3c, 1'b0);
    send_item(lsfw_pkg::OP_DATA, 8'h00, 7'h00, 8'h00, 1'b1);
    directed = items_sent;

    // random: mostly bursts ending on eob, some commands and unfinished bursts
    while (items_sent < directed + RANDOM_ITEMS) begin
      if (items_sent >= directed + RANDOM_ITEMS - CALM_ITEMS) idle_on <= 1'b0;
      if (!paused && items_sent >= directed + RANDOM_ITEMS / 2) begin
        drain_slots();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 3) begin
        send_item(lsfw_pkg::OP_CMD, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 6);
        cut = ($urandom_range(0, 7) == 0);
        for (k = 0; k < len; k++)
          send_item(lsfw_pkg::OP_DATA, 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                    (k == len - 1) && !cut);
      end
    end

    drain_slots();
    repeat (40) @(posedge clk);

    $display("run covered %0d items: %0d command frames and %0d data bytes",
             items_sent, board.cmd_items, board.data_items);
    $display("%0d bit slots compared, %0d bursts ended early by a command",
             board.slots_checked, board.cut_bursts);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("timeout with %0d slots still expected", board.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
design/lsfw_pkg.sv
design/lsfw_sequencer.sv
design/lsfw_datapath.sv
design/led_driver_serial_frame_writer.sv
verif/led_driver_serial_frame_writer_tb.sv
